@@ hdl/tsp_pkg.sv @@
// Shared types, constants, microprogram and helpers for the step panner.
`default_nettype none

package tsp_pkg;

  // Field widths
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned START_W     = 2;
  localparam int unsigned COEFF_W     = 24;
  localparam int unsigned STEP_W      = 2;
  localparam int unsigned FRAC_BITS   = 24;

  // Internal datapath widths
  localparam int unsigned PAN_W   = FRAC_BITS + 2;    // Q1.24 pan, [-1, +1]
  localparam int unsigned PANX_W  = FRAC_BITS + 4;    // pan sum before clamping
  localparam int unsigned DIFF_W  = FRAC_BITS + 3;    // pan minus target
  localparam int unsigned MONO_W  = SAMPLE_BITS + 1;  // left plus right
  localparam int unsigned GAIN_W  = FRAC_BITS + 1;    // gain in [0, 1] Q0.24
  localparam int unsigned MUL_A_W = DIFF_W;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Fixed-point constants
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PANX_W-1:0] PAN_MAX    = PANX_W'(64'd1 << FRAC_BITS);
  localparam logic signed [PANX_W-1:0] PAN_MIN    = -PAN_MAX;
  localparam logic [PAN_W-1:0]         PAN_BIAS   = PAN_W'(64'd1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] SAMPLE_MAX =
    PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [PROD_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - PROD_W'(1);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_COEFF  = CFG_IDX_W'(2);
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP = PHASE_W'(44739);
  localparam logic [START_W-1:0] RST_START_POS  = START_W'(0);
  localparam logic [COEFF_W-1:0] RST_LAG_COEFF  = COEFF_W'(16772556);

  // Pan pattern: row is start position, column is step (-1 left, 0 centre, +1 right)
  localparam logic signed [1:0] PAN_PATTERN [4][4] = '{
    '{-2'sd1,  2'sd0,  2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd1,  2'sd0, -2'sd1},
    '{ 2'sd1,  2'sd0, -2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd0,  2'sd0,  2'sd0}
  };

  // Payload of each channel
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          sync;
    logic [PHASE_W-1:0]            sync_phase;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [STEP_W-1:0]             step_index;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [START_W-1:0] start_position;
    logic [COEFF_W-1:0] lag_coeff;
  } cfg_t;

  // Microcode
  localparam int unsigned UC_LEN = 12;
  localparam int unsigned UPC_W  = $clog2(UC_LEN);
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_LOAD,        // capture frame, optional phase reload, mono mix
    OP_DIFF,        // pan minus step target
    OP_MUL_LAG,     // lag coefficient times difference
    OP_PAN,         // round, add target, clamp
    OP_MUL_IDX,     // biased pan, halved, times table depth
    OP_IDX,         // round and clamp table index
    OP_RD_R,        // table read for right gain
    OP_MUL_R_RD_L,  // mono times right gain, table read for left gain
    OP_SAT_R,       // round and saturate right
    OP_MUL_L,       // mono times left gain
    OP_SAT_L,       // round and saturate left
    OP_EMIT         // load output register, advance phase
  } uop_t;

  typedef enum logic [1:0] {
    C_NEXT,      // fall through
    C_JUMP,      // unconditional jump to target
    C_WAIT_IN,   // hold until an input transfer, then fall through
    C_WAIT_OUT   // hold while output register is full and stalled, then jump
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } ucode_t;

  localparam ucode_t UCODE [UC_LEN] = '{
    '{OP_LOAD,       C_WAIT_IN,  UPC_W'(0)},
    '{OP_DIFF,       C_NEXT,     UPC_W'(0)},
    '{OP_MUL_LAG,    C_NEXT,     UPC_W'(0)},
    '{OP_PAN,        C_NEXT,     UPC_W'(0)},
    '{OP_MUL_IDX,    C_NEXT,     UPC_W'(0)},
    '{OP_IDX,        C_NEXT,     UPC_W'(0)},
    '{OP_RD_R,       C_NEXT,     UPC_W'(0)},
    '{OP_MUL_R_RD_L, C_NEXT,     UPC_W'(0)},
    '{OP_SAT_R,      C_NEXT,     UPC_W'(0)},
    '{OP_MUL_L,      C_NEXT,     UPC_W'(0)},
    '{OP_SAT_L,      C_NEXT,     UPC_W'(0)},
    '{OP_EMIT,       C_WAIT_OUT, UPC_W'(0)}
  };

  // Control from sequencer to datapath
  typedef struct packed {
    uop_t op;
    logic fire;    // the current step executes this cycle
    logic take;    // the sequencer is waiting for an input frame
  } ctrl_t;

  // Round a Q.24 product to nearest and saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] v;
    v = (prod + ROUND_HALF) >>> FRAC_BITS;
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/tsp_rom.sv @@
// Quarter-wave sine gain ROM, contents worked out at elaboration, registered read.
`default_nettype none

module tsp_rom #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH+1)-1:0]    rd_addr,
  output logic [tsp_pkg::GAIN_W-1:0]         rd_data_r
);

  localparam int unsigned AW = $clog2(DEPTH + 1);

  // sin(idx / DEPTH * pi/2) in Q0.24 by fixed-point Taylor series
  function automatic logic [tsp_pkg::GAIN_W-1:0] sine_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (64'(idx) * tsp_pkg::HALF_PI_Q30) / DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 32) >>> 6;
    if (sum > 64'sd16777216) begin
      sum = 64'sd16777216;
    end
    return sum[tsp_pkg::GAIN_W-1:0];
  endfunction

  logic [tsp_pkg::GAIN_W-1:0] rom_w [DEPTH+1];

  // Constant contents
  for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
    localparam logic [tsp_pkg::GAIN_W-1:0] ENTRY = sine_entry(g);
    assign rom_w[g] = ENTRY;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_w[rd_addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tsp_seq.sv @@
// Microprogram sequencer: step counter, control store and conditional jumps.
`default_nettype none

module tsp_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            out_busy,
  output tsp_pkg::ctrl_t       ctrl
);

  tsp_pkg::upc_t   upc_r;
  tsp_pkg::upc_t   upc_nxt;
  tsp_pkg::ucode_t word;
  logic            fire;

  assign word = tsp_pkg::UCODE[upc_r];

  // Next step and execute condition
  always_comb begin
    fire    = 1'b1;
    upc_nxt = upc_r;
    case (word.cond)
      tsp_pkg::C_NEXT: begin
        upc_nxt = upc_r + tsp_pkg::UPC_W'(1);
      end
      tsp_pkg::C_JUMP: begin
        upc_nxt = word.target;
      end
      tsp_pkg::C_WAIT_IN: begin
        fire = in_valid;
        if (in_valid) begin
          upc_nxt = upc_r + tsp_pkg::UPC_W'(1);
        end
      end
      tsp_pkg::C_WAIT_OUT: begin
        fire = !out_busy;
        if (!out_busy) begin
          upc_nxt = word.target;
        end
      end
      default: begin
        fire    = 1'b0;
        upc_nxt = '0;
      end
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= '0;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Control word out
  always_comb begin
    ctrl.op   = word.op;
    ctrl.fire = fire;
    ctrl.take = (word.cond == tsp_pkg::C_WAIT_IN);
  end

endmodule

`default_nettype wire

@@ hdl/tsp_dp.sv @@
// Datapath: phase and pan state, shared multiplier, gain ROM and output register.
`default_nettype none

module tsp_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  tsp_pkg::ctrl_t           ctrl,
  input  tsp_pkg::cfg_t            cfg,
  input  tsp_pkg::in_item_t        in_data,
  output logic                     out_busy,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tsp_pkg::out_item_t       out_data
);

  localparam int unsigned KW = $clog2(DEPTH + 1);
  localparam logic [KW-1:0] K_MAX = KW'(DEPTH);

  // State and working registers
  logic [tsp_pkg::PHASE_W-1:0]          phase_r, phase_nxt;
  logic signed [tsp_pkg::PAN_W-1:0]     pan_r, pan_nxt;
  logic signed [tsp_pkg::MONO_W-1:0]    mono_r, mono_nxt;
  logic signed [tsp_pkg::DIFF_W-1:0]    diff_r, diff_nxt;
  logic signed [tsp_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [KW-1:0]                        k_r, k_nxt;
  logic signed [tsp_pkg::SAMPLE_BITS-1:0] rres_r, rres_nxt;
  logic signed [tsp_pkg::SAMPLE_BITS-1:0] lres_r, lres_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  tsp_pkg::out_item_t                   out_data_r, out_data_nxt;

  // Combinational helpers
  logic [tsp_pkg::STEP_W-1:0]           step;
  logic signed [tsp_pkg::PAN_W-1:0]     target;
  logic signed [tsp_pkg::PROD_W-1:0]    rnd;
  logic signed [tsp_pkg::PANX_W-1:0]    pan_sum;
  logic [tsp_pkg::PAN_W-1:0]            pan_biased;
  logic signed [tsp_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [tsp_pkg::MUL_B_W-1:0]   mul_b;
  logic                                 rom_en;
  logic [KW-1:0]                        rom_addr;
  logic [tsp_pkg::GAIN_W-1:0]           rom_q;

  // Step and pan target from phase and pattern
  assign step   = phase_r[tsp_pkg::PHASE_W-1 -: tsp_pkg::STEP_W];
  assign target = tsp_pkg::PAN_W'(tsp_pkg::PAN_PATTERN[cfg.start_position][step])
                  <<< tsp_pkg::FRAC_BITS;

  // Rounded Q.24 product and pan arithmetic
  assign rnd        = (prod_r + tsp_pkg::ROUND_HALF) >>> tsp_pkg::FRAC_BITS;
  assign pan_sum    = tsp_pkg::PANX_W'(target) + $signed(rnd[tsp_pkg::PANX_W-1:0]);
  assign pan_biased = pan_r + tsp_pkg::PAN_BIAS;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      tsp_pkg::OP_MUL_LAG: begin
        mul_a = diff_r;
        mul_b = {2'b00, cfg.lag_coeff};
      end
      tsp_pkg::OP_MUL_IDX: begin
        mul_a = {2'b00, pan_biased[tsp_pkg::PAN_W-1:1]};
        mul_b = tsp_pkg::MUL_B_W'(DEPTH);
      end
      tsp_pkg::OP_MUL_R_RD_L, tsp_pkg::OP_MUL_L: begin
        mul_a = tsp_pkg::MUL_A_W'(mono_r);
        mul_b = {1'b0, rom_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Gain ROM port
  assign rom_en   = ctrl.fire && (ctrl.op == tsp_pkg::OP_RD_R ||
                                  ctrl.op == tsp_pkg::OP_MUL_R_RD_L);
  assign rom_addr = (ctrl.op == tsp_pkg::OP_RD_R) ? k_r : K_MAX - k_r;

  tsp_rom #(
    .DEPTH(DEPTH)
  ) u_rom (
    .clk      (clk),
    .rd_en    (rom_en),
    .rd_addr  (rom_addr),
    .rd_data_r(rom_q)
  );

  // Micro-operation execution
  always_comb begin
    phase_nxt     = phase_r;
    pan_nxt       = pan_r;
    mono_nxt      = mono_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    k_nxt         = k_r;
    rres_nxt      = rres_r;
    lres_nxt      = lres_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctrl.fire) begin
      case (ctrl.op)
        tsp_pkg::OP_LOAD: begin
          mono_nxt = tsp_pkg::MONO_W'(in_data.left_sample)
                   + tsp_pkg::MONO_W'(in_data.right_sample);
          if (in_data.sync) begin
            phase_nxt = in_data.sync_phase;
          end
        end
        tsp_pkg::OP_DIFF: begin
          diff_nxt = tsp_pkg::DIFF_W'(pan_r) - tsp_pkg::DIFF_W'(target);
        end
        tsp_pkg::OP_MUL_LAG, tsp_pkg::OP_MUL_IDX, tsp_pkg::OP_MUL_R_RD_L,
        tsp_pkg::OP_MUL_L: begin
          prod_nxt = mul_a * mul_b;
        end
        tsp_pkg::OP_PAN: begin
          if (pan_sum > tsp_pkg::PAN_MAX) begin
            pan_nxt = tsp_pkg::PAN_W'(tsp_pkg::PAN_MAX);
          end else if (pan_sum < tsp_pkg::PAN_MIN) begin
            pan_nxt = tsp_pkg::PAN_W'(tsp_pkg::PAN_MIN);
          end else begin
            pan_nxt = pan_sum[tsp_pkg::PAN_W-1:0];
          end
        end
        tsp_pkg::OP_IDX: begin
          if ($unsigned(rnd) > tsp_pkg::PROD_W'(DEPTH)) begin
            k_nxt = K_MAX;
          end else begin
            k_nxt = rnd[KW-1:0];
          end
        end
        tsp_pkg::OP_SAT_R: begin
          rres_nxt = tsp_pkg::round_sat(prod_r);
        end
        tsp_pkg::OP_SAT_L: begin
          lres_nxt = tsp_pkg::round_sat(prod_r);
        end
        tsp_pkg::OP_EMIT: begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.left_out   = lres_r;
          out_data_nxt.right_out  = rres_r;
          out_data_nxt.step_index = step;
          phase_nxt               = phase_r + cfg.phase_step;
        end
        default: begin
          out_valid_nxt = out_valid_r && out_stall;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      pan_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pan_r       <= pan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    mono_r     <= mono_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    k_r        <= k_nxt;
    rres_r     <= rres_nxt;
    lres_r     <= lres_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_busy  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/tempo_synced_step_panner_top.sv @@
// Top level of the tempo-synced constant-power step panner.
// A result enters the output register at the end of the microprogram that its input
// transfer starts; that microprogram shares one multiplier and one single-port gain ROM,
// so a new frame is taken only after it ends, and later while out_stall holds.
// A finished result waits in the output register while the next frame is taken.
// Reset (rst_n low, synchronous): phase and pan to zero, registers to defaults.
`default_nettype none

module tempo_synced_step_panner_top #(
  parameter int unsigned GAIN_TABLE_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  tsp_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tsp_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [tsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsp_pkg::PHASE_W-1:0]      cfg_wdata
);

  tsp_pkg::cfg_t  cfg_r;
  tsp_pkg::cfg_t  cfg_nxt;
  tsp_pkg::ctrl_t ctrl;
  logic           out_busy;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tsp_pkg::CFG_PHASE_STEP: cfg_nxt.phase_step     = cfg_wdata;
        tsp_pkg::CFG_START_POS:  cfg_nxt.start_position = cfg_wdata[tsp_pkg::START_W-1:0];
        tsp_pkg::CFG_LAG_COEFF:  cfg_nxt.lag_coeff      = cfg_wdata[tsp_pkg::COEFF_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step     <= tsp_pkg::RST_PHASE_STEP;
      cfg_r.start_position <= tsp_pkg::RST_START_POS;
      cfg_r.lag_coeff      <= tsp_pkg::RST_LAG_COEFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer
  tsp_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .out_busy(out_busy),
    .ctrl    (ctrl)
  );

  assign in_stall = !ctrl.take;

  // Datapath
  tsp_dp #(
    .DEPTH(GAIN_TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_busy (out_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/tsp_chk.sv @@
// Port-level checker for the step panner and its bind to the top level.
`default_nettype none

module tsp_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input tsp_pkg::out_item_t                 out_data
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn under stall");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed under stall");

  // Frame in work: no second transfer in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a frame is in work");

  // A new result only appears from the end of the program, never while idle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while waiting for input");

endmodule

bind tempo_synced_step_panner_top tsp_chk u_chk (.*);

`default_nettype wire

@@ tb/pan_frame_checker.sv @@
// Predicts each panned frame of the step panner and compares it with the block's results.
module pan_frame_checker #(
  parameter int unsigned GAIN_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  tsp_pkg::in_item_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  tsp_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsp_pkg::PHASE_W-1:0]         cfg_wdata,
  output int unsigned                         err_count,
  output int unsigned                         pending,
  output int unsigned                         matched
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNITY    = longint'(1) << 24;
  localparam longint HALF_LSB = longint'(1) << 23;
  localparam longint DEPTH    = longint'(GAIN_TABLE_DEPTH);

  // Pan target per start position (row) and step (column): -1 left, 0 centre, +1 right
  localparam int STEP_TARGET [4][4] = '{
    '{-1, 0,  1,  0},
    '{ 0, 1,  0, -1},
    '{ 1, 0, -1,  0},
    '{ 0, 0,  0,  0}
  };

  // Shadow of the register set
  logic [31:0] step_inc;
  logic [1:0]  start_sel;
  logic [23:0] lag_c;

  // Shadow of the panner state
  logic [31:0] phase_acc;
  longint      pan_now;

  logic [24:0] gain_rom [0:GAIN_TABLE_DEPTH];

  tsp_pkg::out_item_t expected_frames [$];

  // Quarter-wave sine in Q0.24 from an integer Taylor series of a Q2.30 angle
  function automatic logic [24:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int unsigned     k;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32) >>> 6;
    if (acc > UNITY) acc = UNITY;
    return acc[24:0];
  endfunction

  function automatic logic signed [23:0] clip_sample(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // One frame through the panner: phase reload, lag, gain lookup, mix, phase advance
  function automatic tsp_pkg::out_item_t pan_frame(input tsp_pkg::in_item_t f);
    tsp_pkg::out_item_t r;
    logic [1:0]  step;
    longint      target;
    longint      pan;
    longint      u;
    longint      k;
    longint      mono;
    if (f.sync) phase_acc = f.sync_phase;
    step   = phase_acc[31:30];
    target = longint'(STEP_TARGET[start_sel][step]) * UNITY;
    pan    = target + ((longint'(lag_c) * (pan_now - target) + HALF_LSB) >>> 24);
    if (pan > UNITY) pan = UNITY;
    if (pan < -UNITY) pan = -UNITY;
    pan_now = pan;
    u = (pan + UNITY) >>> 1;
    k = (u * DEPTH + HALF_LSB) >>> 24;
    if (k > DEPTH) k = DEPTH;
    mono = longint'(f.left_sample) + longint'(f.right_sample);
    r.left_out   = clip_sample((mono * longint'(gain_rom[DEPTH - k]) + HALF_LSB) >>> 24);
    r.right_out  = clip_sample((mono * longint'(gain_rom[k]) + HALF_LSB) >>> 24);
    r.step_index = step;
    phase_acc = phase_acc + step_inc;
    return r;
  endfunction

  initial begin
    for (int unsigned i = 0; i <= GAIN_TABLE_DEPTH; i++) begin
      gain_rom[i] = quarter_sine((longint'(i) * tsp_pkg::HALF_PI_Q30) / DEPTH);
    end
  end

  // Track registers, predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    tsp_pkg::out_item_t want;
    if (!rst_n) begin
      step_inc  = tsp_pkg::RST_PHASE_STEP;
      start_sel = tsp_pkg::RST_START_POS;
      lag_c     = tsp_pkg::RST_LAG_COEFF;
      phase_acc = '0;
      pan_now   = 0;
      err_count = 0;
      matched   = 0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tsp_pkg::CFG_PHASE_STEP: step_inc  = cfg_wdata;
          tsp_pkg::CFG_START_POS:  start_sel = cfg_wdata[1:0];
          tsp_pkg::CFG_LAG_COEFF:  lag_c     = cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_frames.push_back(pan_frame(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t ns: result with none expected: left %0d right %0d step %0d",
                   $time, out_data.left_out, out_data.right_out, out_data.step_index);
          err_count++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $display("%0t ns: left_out expected %0d, got %0d",
                     $time, want.left_out, out_data.left_out);
            err_count++;
          end
          if (out_data.right_out !== want.right_out) begin
            $display("%0t ns: right_out expected %0d, got %0d",
                     $time, want.right_out, out_data.right_out);
            err_count++;
          end
          if (out_data.step_index !== want.step_index) begin
            $display("%0t ns: step_index expected %0d, got %0d",
                     $time, want.step_index, out_data.step_index);
            err_count++;
          end
          matched++;
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

@@ tb/tempo_synced_step_panner_top_tb.sv @@
// Stimulus, clock, reset and verdict for the tempo-synced step panner.
module tempo_synced_step_panner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GAIN_DEPTH  = 1024;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tsp_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_stall;
  tsp_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tsp_pkg::PHASE_W-1:0]   cfg_wdata;

  int unsigned err_count;
  int unsigned pending;
  int unsigned matched;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_pending   = 1'b0;
  int unsigned frames_sent    = 0;
  int unsigned settings_used  = 0;

  tempo_synced_step_panner_top #(
    .GAIN_TABLE_DEPTH(GAIN_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  pan_frame_checker #(
    .GAIN_TABLE_DEPTH(GAIN_DEPTH)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .err_count(err_count),
    .pending  (pending),
    .matched  (matched)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: optional long hold-off, otherwise random stalls
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic tsp_pkg::in_item_t make_frame(input logic signed [23:0] l,
                                                   input logic signed [23:0] r,
                                                   input logic sy, input logic [31:0] ph);
    tsp_pkg::in_item_t f;
    f.left_sample  = l;
    f.right_sample = r;
    f.sync         = sy;
    f.sync_phase   = ph;
    return f;
  endfunction

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return 24'sd0;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one frame, wait for its transfer, then maybe leave the channel idle
  task automatic send_frame(input tsp_pkg::in_item_t f);
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop offering and wait until every predicted frame has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] step, input logic [1:0] pos,
                            input logic [23:0] coeff);
    cfg_we    <= 1'b1;
    cfg_index <= tsp_pkg::CFG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= tsp_pkg::CFG_START_POS;
    cfg_wdata <= 32'(pos);
    @(posedge clk);
    cfg_index <= tsp_pkg::CFG_LAG_COEFF;
    cfg_wdata <= 32'(coeff);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [31:0] step;
    logic [23:0] coeff;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= tsp_pkg::CFG_PHASE_STEP;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: slow lag from centre, phase from zero
    settings_used = 1;
    send_frame(make_frame(S_MAX, S_MIN, 1'b0, 32'h0));
    send_frame(make_frame(24'sd1000, 24'sd2000, 1'b0, 32'hFFFFFFFF));
    send_frame(make_frame(S_MAX, S_MAX, 1'b0, 32'h0));
    drain_results();

    // Instant pan, one step per frame: left, centre, right, centre; saturation both ways
    write_regs(32'h40000000, 2'd0, 24'd0);
    send_frame(make_frame(S_MAX, S_MAX, 1'b1, 32'h0));
    send_frame(make_frame(S_MIN, S_MIN, 1'b0, 32'h0));
    send_frame(make_frame(S_MAX, S_MIN, 1'b0, 32'h0));
    send_frame(make_frame(24'sd0, 24'sd0, 1'b0, 32'h0));
    send_frame(make_frame(24'sd1, -24'sd1, 1'b0, 32'h0));
    send_frame(make_frame(S_MIN, S_MAX, 1'b1, 32'hBFFFFFFF));
    drain_results();

    // Phase wrap with the largest step and the slowest lag
    write_regs(32'hFFFFFFFF, 2'd1, 24'hFFFFFF);
    send_frame(make_frame(S_MAX, S_MAX, 1'b1, 32'hFFFFFFFF));
    send_frame(make_frame(S_MIN, S_MIN, 1'b0, 32'h0));
    send_frame(make_frame(-24'sd1, -24'sd1, 1'b1, 32'h0));
    send_frame(make_frame(24'sd4194304, 24'sd4194304, 1'b0, 32'h0));
    drain_results();

    write_regs(32'h40000000, 2'd2, 24'd0);
    send_frame(make_frame(S_MAX, S_MAX, 1'b1, 32'h0));
    send_frame(make_frame(S_MIN, S_MIN, 1'b0, 32'h0));
    send_frame(make_frame(S_MAX, S_MAX, 1'b0, 32'h0));
    send_frame(make_frame(S_MIN, 24'sd0, 1'b0, 32'h0));
    drain_results();

    // Unused start selector keeps the pan centred
    write_regs(32'h40000000, 2'd3, 24'd0);
    send_frame(make_frame(S_MAX, S_MAX, 1'b1, 32'h80000000));
    send_frame(make_frame(S_MIN, S_MIN, 1'b0, 32'h0));
    send_frame(make_frame(24'sd12345, -24'sd54321, 1'b0, 32'h0));
    drain_results();

    // Random phases, each with its own register setting and idling pattern
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       step = $urandom;
        1:       step = 32'h0;
        2:       step = 32'hFFFFFFFF;
        3:       step = $urandom_range(1, 1 << 22);
        4:       step = 32'h40000000;
        5:       step = 32'd1;
        6:       step = $urandom_range(0, 1 << 26);
        default: step = $urandom;
      endcase
      case (p)
        0:       coeff = 24'd0;
        1:       coeff = 24'hFFFFFF;
        2:       coeff = 24'($urandom);
        3:       coeff = tsp_pkg::RST_LAG_COEFF;
        4:       coeff = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
        5:       coeff = 24'd0;
        6:       coeff = 24'($urandom_range(0, 1 << 20));
        default: coeff = 24'($urandom);
      endcase
      write_regs(step, 2'(p % 4), coeff);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
      // Long receiver hold-off while frames keep coming, to back the block up
      if (p == 0) hold_pending = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-phase pause until every result is back
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        send_frame(make_frame(pick_sample(), pick_sample(),
                              ($urandom_range(7) == 0), $urandom));
      end
      drain_results();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d frames and %0d checked results over %0d register settings,",
             frames_sent, matched, settings_used);
    $display("including saturation, phase wrap, phase reloads and the unused start selector.");
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
